### hdl/clpbs_pkg.sv
`default_nettype none

package clpbs_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    localparam logic [15:0] SETUP_RST  = 16'd120;
    localparam logic [15:0] ENABLE_RST = 16'd80;
    localparam logic [15:0] HOLD_RST   = 16'd20;
    localparam logic [15:0] CYCLE_RST  = 16'd400;

    localparam logic [3:0] CMD_NONE = 4'd0;
    localparam logic [3:0] CMD_BUSY = 4'd9;
    localparam logic [3:0] CMD_WRAM = 4'd10;
    localparam logic [3:0] CMD_RRAM = 4'd11;

    localparam int BUSY_BIT = 7;

    localparam logic [1:0] REG_SETUP  = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_HOLD   = 2'd2;
    localparam logic [1:0] REG_CYCLE  = 2'd3;

    // result item bit positions
    localparam int OUT_RS   = 0;
    localparam int OUT_RW   = 1;
    localparam int OUT_EN   = 2;
    localparam int OUT_BUSY = 12;
    localparam int OUT_DONE = 13;
    localparam int OUT_RVAL = 14;

    typedef struct packed {
        logic       req;
        logic       poll;
        logic       rd;
        logic       ram;
        logic [7:0] drive_byte;
        logic [7:0] bus_in;
    } item_t;

    typedef struct packed {
        logic [15:0] setup;
        logic [15:0] enable;
        logic [15:0] hold;
        logic [15:0] cycle;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/clpbs_front.sv
`default_nettype none

module clpbs_front
(
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [clpbs_pkg::IN_W-1:0]    s_axis_tdata,
    input  wire logic                          q_full,
    output logic                               q_push,
    output clpbs_pkg::item_t                   q_item
);

    logic [3:0] cmd;
    logic [7:0] data;
    logic [2:0] shift_amt;
    logic [7:0] instr_byte;

    assign cmd  = s_axis_tdata[3:0];
    assign data = s_axis_tdata[11:4];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign shift_amt  = 3'(cmd - 4'd1);
    assign instr_byte = (8'd1 << shift_amt) | data;

    always_comb
    begin
        q_item.req        = (cmd != clpbs_pkg::CMD_NONE) && (cmd <= clpbs_pkg::CMD_RRAM);
        q_item.poll       = (cmd != clpbs_pkg::CMD_BUSY);
        q_item.rd         = (cmd == clpbs_pkg::CMD_BUSY) || (cmd == clpbs_pkg::CMD_RRAM);
        q_item.ram        = (cmd == clpbs_pkg::CMD_WRAM) || (cmd == clpbs_pkg::CMD_RRAM);
        q_item.drive_byte = (cmd == clpbs_pkg::CMD_WRAM) ? data : instr_byte;
        q_item.bus_in     = s_axis_tdata[19:12];
    end

endmodule

`default_nettype wire

### hdl/clpbs_queue.sv
`default_nettype none

module clpbs_queue
#(
    parameter int DEPTH = clpbs_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire clpbs_pkg::item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output clpbs_pkg::item_t       head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clpbs_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hdl/clpbs_back.sv
`default_nettype none

module clpbs_back
#(
    parameter int COUNT_WIDTH = clpbs_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire clpbs_pkg::cfg_t               cfg,
    input  wire logic                          head_valid,
    input  wire clpbs_pkg::item_t              head_item,
    output logic                               pop,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [clpbs_pkg::OUT_W-1:0]        m_axis_tdata
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SETUP  = 5'b00010,
        PH_ENABLE = 5'b00100,
        PH_HOLD   = 5'b01000,
        PH_CYCLE  = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic                   held_rw_reg, held_rw_next;
    logic                   held_rs_reg, held_rs_next;
    logic [7:0]             held_drive_reg, held_drive_next;
    logic                   polling_reg, polling_next;
    logic [7:0]             captured_reg, captured_next;
    logic                   dir_reg, dir_next;
    logic [7:0]             driven_reg, driven_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [clpbs_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [15:0]            limit;
    logic                   over;
    logic                   done;
    logic [7:0]             rval;
    logic                   rs, rw;

    assign pop           = head_valid && (!m_tvalid_reg || m_axis_tready);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    always_comb
    begin
        case (phase_reg)
            PH_SETUP:  limit = cfg.setup;
            PH_ENABLE: limit = cfg.enable;
            PH_HOLD:   limit = cfg.hold;
            PH_CYCLE:  limit = cfg.cycle;
            default:   limit = '0;
        endcase
    end

    assign over = (CMP_W'(tick_reg) >= CMP_W'(limit)) || (tick_reg == {COUNT_WIDTH{1'b1}});

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = over ? '0 : tick_reg + COUNT_WIDTH'(1);
        held_rw_next    = held_rw_reg;
        held_rs_next    = held_rs_reg;
        held_drive_next = held_drive_reg;
        polling_next    = polling_reg;
        captured_next   = captured_reg;
        dir_next        = dir_reg;
        driven_next     = driven_reg;
        done            = 1'b0;
        rval            = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                tick_next = tick_reg;
                if (head_item.req)
                begin
                    held_rw_next    = head_item.rd;
                    held_rs_next    = head_item.ram;
                    held_drive_next = head_item.drive_byte;
                    polling_next    = head_item.poll;
                    tick_next       = '0;
                    phase_next      = PH_SETUP;
                end
            end
            PH_SETUP:
            begin
                if (over)
                begin
                    if (polling_reg || held_rw_reg)
                    begin
                        captured_next = head_item.bus_in;
                        dir_next      = 1'b0;
                    end
                    else
                    begin
                        driven_next = held_drive_reg;
                        dir_next    = 1'b1;
                    end
                    phase_next = PH_ENABLE;
                end
            end
            PH_ENABLE:
            begin
                if (over)
                begin
                    phase_next = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (over)
                begin
                    driven_next = '0;
                    phase_next  = PH_CYCLE;
                end
            end
            PH_CYCLE:
            begin
                if (over)
                begin
                    if (polling_reg)
                    begin
                        if (!captured_reg[clpbs_pkg::BUSY_BIT])
                        begin
                            polling_next = 1'b0;
                        end
                        phase_next = PH_SETUP;
                    end
                    else
                    begin
                        done       = 1'b1;
                        rval       = held_rw_reg ? captured_reg : 8'd0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    assign rs = polling_next ? 1'b0 : held_rs_next;
    assign rw = polling_next ? 1'b1 : held_rw_next;

    always_comb
    begin
        m_tdata_next  = {2'b00, rval, done, (phase_next != PH_IDLE), dir_next, driven_next,
                         (phase_next == PH_ENABLE), rw, rs};
        m_tvalid_next = pop ? 1'b1 : (m_axis_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            held_rw_reg    <= 1'b0;
            held_rs_reg    <= 1'b0;
            held_drive_reg <= '0;
            polling_reg    <= 1'b0;
            captured_reg   <= '0;
            dir_reg        <= 1'b1;
            driven_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (pop)
            begin
                phase_reg      <= phase_next;
                tick_reg       <= tick_next;
                held_rw_reg    <= held_rw_next;
                held_rs_reg    <= held_rs_next;
                held_drive_reg <= held_drive_next;
                polling_reg    <= polling_next;
                captured_reg   <= captured_next;
                dir_reg        <= dir_next;
                driven_reg     <= driven_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

### hdl/char_lcd_parallel_bus_sequencer.sv
`default_nettype none

// channel   dir   handshake                   payload
// s_axis    in    s_axis_tvalid/tready        cmd, data, bus_in (one clock tick of the lcd bus)
// m_axis    out   m_axis_tvalid/tready        pin state, busy, done, read value for that tick
// apb       in    psel/penable/pready         setup, enable, hold, cycle tick counts
//
// one item in, one item out; an item is taken every cycle unless the queue is full
// the sequencer state advances once per item, one tick per unstalled cycle, no internal waits
// a four-entry queue sits between decode and sequencer; the result register is
// reloaded while the previous result is taken, so m_axis stalls hold sequencer and queue
// rst_n async active low: bus idle, pins driven, data latch zero, counts at defaults

module char_lcd_parallel_bus_sequencer
#(
    parameter int COUNT_WIDTH = clpbs_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = clpbs_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd[3:0], data[11:4], bus_in[19:12], zero fill
    input  wire logic [clpbs_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // reg_select[0], read_not_write[1], enable[2], bus_out[10:3], bus_drive[11],
    // busy_res[12], done_res[13], read_value[21:14], zero fill
    output logic [clpbs_pkg::OUT_W-1:0]        m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    clpbs_pkg::cfg_t  cfg_reg, cfg_next;
    clpbs_pkg::item_t q_in_item, q_head_item;
    logic             q_full, q_push, q_pop, q_valid;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                clpbs_pkg::REG_SETUP:  cfg_next.setup  = pwdata[15:0];
                clpbs_pkg::REG_ENABLE: cfg_next.enable = pwdata[15:0];
                clpbs_pkg::REG_HOLD:   cfg_next.hold   = pwdata[15:0];
                clpbs_pkg::REG_CYCLE:  cfg_next.cycle  = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            clpbs_pkg::REG_SETUP:  prdata = {16'd0, cfg_reg.setup};
            clpbs_pkg::REG_ENABLE: prdata = {16'd0, cfg_reg.enable};
            clpbs_pkg::REG_HOLD:   prdata = {16'd0, cfg_reg.hold};
            clpbs_pkg::REG_CYCLE:  prdata = {16'd0, cfg_reg.cycle};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup  <= clpbs_pkg::SETUP_RST;
            cfg_reg.enable <= clpbs_pkg::ENABLE_RST;
            cfg_reg.hold   <= clpbs_pkg::HOLD_RST;
            cfg_reg.cycle  <= clpbs_pkg::CYCLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clpbs_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in_item)
    );

    clpbs_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head_item)
    );

    clpbs_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (q_valid),
        .head_item     (q_head_item),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[clpbs_pkg::OUT_DONE]
        |-> !m_axis_tdata[clpbs_pkg::OUT_BUSY] && !m_axis_tdata[clpbs_pkg::OUT_EN])
        else $error("done while bus cycle still running");

    a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[clpbs_pkg::OUT_EN] |-> m_axis_tdata[clpbs_pkg::OUT_BUSY])
        else $error("enable high outside a request");

    a_rval_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[clpbs_pkg::OUT_DONE]
        |-> m_axis_tdata[clpbs_pkg::OUT_RVAL+7:clpbs_pkg::OUT_RVAL] == 8'd0)
        else $error("read value without done");

endmodule

`default_nettype wire
